### src/shs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-256 stream hasher.
// Depends on nothing; the design modules and the testbench files import it.
package shs_pkg;

  // Input action codes.
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] ROUND_LAST = 7'd64;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_FOLD,
    S_EMIT
  } state_t;

  // What a compression pass sees: a full data block, data with the pad byte
  // and the length, data with the pad byte only, or the length alone.
  typedef enum logic [1:0] {
    BLK_FULL,
    BLK_PAD_LEN,
    BLK_PAD,
    BLK_LEN
  } blk_kind_t;

  typedef struct packed {
    logic        wr_byte;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_data;
    logic        sched_en;
    logic [5:0]  t;
    blk_kind_t   kind;
    logic [5:0]  fill;
    logic [63:0] total_bits;
  } sched_ctl_t;

  typedef struct packed {
    logic       init_work;
    logic       round_en;
    logic [5:0] round_t;
    logic       fold;
    logic       shift_out;
    logic       reload_iv;
  } round_ctl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### src/shs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the SHA-256 stream hasher: one word per handshake.
// Depends on nothing.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] msg_byte;

  modport source (output valid, output action, output msg_byte, input ready);
  modport sink (input valid, input action, input msg_byte, output ready);
endinterface

### src/shs_out_if.sv
`timescale 1ns / 1ps
// Output channel of the SHA-256 stream hasher: one digest word per handshake.
// Depends on nothing.
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

### src/shs_sched.sv
`timescale 1ns / 1ps
// Block buffer and message schedule: sixteen word window, padding insertion.
// Depends on shs_pkg.
module shs_sched (
  input  logic               clk,
  input  shs_pkg::sched_ctl_t ctl,
  output logic [31:0]        w_out
);
  import shs_pkg::*;

  logic [31:0] win [16];
  logic [31:0] w_reg;
  logic [31:0] w_fix;
  logic [31:0] w_exp;
  logic [31:0] w_new;
  logic [5:0]  bpos;
  logic [7:0]  raw;
  logic        has_pad;

  // Except in a full block, bytes beyond the fill level are stale and get replaced by padding.
  always_comb begin
    has_pad = (ctl.kind == BLK_PAD) || (ctl.kind == BLK_PAD_LEN);
    bpos    = '0;
    raw     = '0;
    w_fix   = '0;
    for (int l = 0; l < 4; l++) begin
      bpos = {ctl.t[3:0], 2'(l)};
      raw  = win[0][31 - 8 * l -: 8];
      if (ctl.kind == BLK_FULL || (has_pad && bpos < ctl.fill)) begin
        w_fix[31 - 8 * l -: 8] = raw;
      end else if (has_pad && bpos == ctl.fill) begin
        w_fix[31 - 8 * l -: 8] = PAD_BYTE;
      end else begin
        w_fix[31 - 8 * l -: 8] = 8'h00;
      end
    end
    if (ctl.kind == BLK_LEN || ctl.kind == BLK_PAD_LEN) begin
      if (ctl.t[3:0] == 4'd14) begin
        w_fix = ctl.total_bits[63:32];
      end else if (ctl.t[3:0] == 4'd15) begin
        w_fix = ctl.total_bits[31:0];
      end
    end
  end

  assign w_exp = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w_new = (ctl.t[5:4] == 2'b00) ? w_fix : w_exp;

  always_ff @(posedge clk) begin
    if (ctl.sched_en) begin
      w_reg <= w_new;
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
    end else if (ctl.wr_byte) begin
      win[ctl.wr_pos[5:2]][{~ctl.wr_pos[1:0], 3'b000} +: 8] <= ctl.wr_data;
    end
  end

  assign w_out = w_reg;

endmodule

### src/shs_round.sv
`timescale 1ns / 1ps
// Shared round unit with the working variables and the eight hash words.
// Depends on shs_pkg.
module shs_round (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::round_ctl_t ctl,
  input  logic [31:0]        w_in,
  output logic [31:0]        digest_word
);
  import shs_pkg::*;

  logic [31:0] hv [8];
  logic [31:0] wv [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  always_comb begin
    choose = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    major  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1     = wv[7] + big_sigma1(wv[4]) + choose + ROUND_K[ctl.round_t] + w_in;
    t2     = big_sigma0(wv[0]) + major;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reload_iv) begin
      hv <= HASH_IV;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= hv[i] + wv[i];
      end
    end else if (ctl.shift_out) begin
      for (int i = 0; i < 7; i++) begin
        hv[i] <= hv[i + 1];
      end
      hv[7] <= hv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init_work) begin
      wv <= hv;
    end else if (ctl.round_en) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  assign digest_word = hv[0];

endmodule

### src/shs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: fill level, bit length, round counter and digest word counter.
// Depends on shs_pkg.
module shs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                action,
  input  logic [7:0]          msg_byte,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          word_index,
  output logic                last_word,
  output shs_pkg::sched_ctl_t sched_ctl,
  output shs_pkg::round_ctl_t round_ctl
);
  import shs_pkg::*;

  state_t      state;
  state_t      state_next;
  blk_kind_t   kind;
  logic [6:0]  cnt;
  logic [5:0]  fill;
  logic [63:0] total_bits;
  logic [2:0]  idx;
  logic        in_acc;
  logic        out_acc;
  logic        emit_done;

  assign in_acc    = in_valid && (state == S_IDLE);
  assign out_acc   = out_ready && (state == S_EMIT);
  assign emit_done = out_acc && (idx == WORD_LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (action == ACT_FINISH || fill == BLOCK_LAST)) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (cnt == ROUND_LAST) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        unique case (kind) inside
          BLK_FULL:          state_next = S_IDLE;
          BLK_PAD:           state_next = S_HASH;
          BLK_PAD_LEN, BLK_LEN: state_next = S_EMIT;
          default:           state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_EMIT);
    word_index = idx;
    last_word  = (idx == WORD_LAST);

    sched_ctl.wr_byte    = in_acc && (action == ACT_ABSORB);
    sched_ctl.wr_pos     = fill;
    sched_ctl.wr_data    = msg_byte;
    sched_ctl.sched_en   = (state == S_HASH) && !cnt[6];
    sched_ctl.t          = cnt[5:0];
    sched_ctl.kind       = kind;
    sched_ctl.fill       = fill;
    sched_ctl.total_bits = total_bits;

    round_ctl.init_work = (state == S_HASH) && (cnt == '0);
    round_ctl.round_en  = (state == S_HASH) && (cnt != '0);
    round_ctl.round_t   = cnt[5:0] - 6'd1;
    round_ctl.fold      = (state == S_FOLD);
    round_ctl.shift_out = out_acc;
    round_ctl.reload_iv = emit_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= BLK_FULL;
      cnt        <= '0;
      fill       <= '0;
      total_bits <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_HASH) ? cnt + 7'd1 : '0;
      idx   <= (state == S_EMIT) ? idx + {2'b00, out_acc} : '0;
      if (in_acc) begin
        if (action == ACT_ABSORB) begin
          fill       <= fill + 6'd1;
          total_bits <= total_bits + BYTE_BITS;
          kind       <= BLK_FULL;
        end else begin
          kind <= (fill < LEN_POS) ? BLK_PAD_LEN : BLK_PAD;
        end
      end else if (state == S_FOLD && kind == BLK_PAD) begin
        kind <= BLK_LEN;
      end else if (emit_done) begin
        fill       <= '0;
        total_bits <= '0;
      end
    end
  end

endmodule

### src/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// SHA-256 stream hasher. An absorb word holds off the input only when it completes a
// 64-byte block, while the single shared round unit runs a schedule lead-in step and
// the 64 rounds, one round per cycle, and a fold step then adds the working variables
// into the hash. A finish word pads the message in flight (no buffer sweep) and takes
// one compression pass when fewer than 56 bytes are buffered and two passes otherwise,
// after which the eight digest words leave H0 first, one per output handshake, with
// word_index counting 0 to 7 and last_word on the eighth. The input is not ready
// from the acceptance of a block-completing word until its fold is done, nor from
// the acceptance of a finish word until the last digest word has been taken; the
// block then starts the next message from the initial hash state.
// Depends on shs_pkg, shs_in_if, shs_out_if, shs_ctrl, shs_sched and shs_round.
module sha256_stream_hasher_top (
  input logic       clk,
  input logic       rst,
  shs_in_if.sink    msg_in,
  shs_out_if.source digest_out
);
  import shs_pkg::*;

  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  logic [31:0] w_cur;

  // Sequencer: owns the handshakes, the fill level and the message length.
  shs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg_in.valid),
    .action     (msg_in.action),
    .msg_byte   (msg_in.msg_byte),
    .in_ready   (msg_in.ready),
    .out_valid  (digest_out.valid),
    .out_ready  (digest_out.ready),
    .word_index (digest_out.word_index),
    .last_word  (digest_out.last_word),
    .sched_ctl  (sched_ctl),
    .round_ctl  (round_ctl)
  );

  // Block buffer that doubles as the schedule window; it inserts the padding
  // and the length words as the block streams out.
  shs_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_out (w_cur)
  );

  // The round unit; the hash words rotate through its first word while the
  // digest is read out.
  shs_round u_round (
    .clk         (clk),
    .rst         (rst),
    .ctl         (round_ctl),
    .w_in        (w_cur),
    .digest_word (digest_out.digest_word)
  );

  // The input is never taken while a digest is being delivered.
  assert property (@(posedge clk) disable iff (rst)
    !(msg_in.ready && digest_out.valid))
    else $error("input ready while digest words are pending");

  // A finish word always starts compression work.
  assert property (@(posedge clk) disable iff (rst)
    (msg_in.valid && msg_in.ready && msg_in.action == ACT_FINISH)
    |=> (!msg_in.ready && !digest_out.valid))
    else $error("finish word did not start compression");

  // Digest words leave in order.
  assert property (@(posedge clk) disable iff (rst)
    (digest_out.valid && digest_out.ready && !digest_out.last_word)
    |=> (digest_out.valid && digest_out.word_index == $past(digest_out.word_index) + 3'd1))
    else $error("digest word index out of sequence");

  // After the last digest word the block is free for the next message.
  assert property (@(posedge clk) disable iff (rst)
    (digest_out.valid && digest_out.ready && digest_out.last_word)
    |=> (msg_in.ready && !digest_out.valid))
    else $error("block not idle after the last digest word");

endmodule

### verif/sha256_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker for the SHA-256 stream hasher: watches both channels, keeps its
// own SHA-256 state and compares every digest word. Depends on shs_pkg and the
// shs_in_if / shs_out_if interfaces.
module sha256_digest_checker (
  input  logic clk,
  input  logic rst,
  shs_in_if    msg_in,
  shs_out_if   digest_out,
  output int   mismatches,
  output int   pending
);
  import shs_pkg::*;

  localparam int         BLOCK_SIZE = 64;
  localparam int         LEN_OFFSET = 56;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam logic [31:0] sha_k [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] iv_words [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [7:0]   blk_bytes [BLOCK_SIZE];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_bits;
  logic [31:0]  chain [8];
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of blk_bytes into the chaining words.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + sha_k[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void restart_message();
    blk_fill = '0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++)
      chain[i] = iv_words[i];
  endfunction

  // Absorb a byte, or pad and close the message and queue its eight words.
  function automatic void predict_word(input logic act, input logic [7:0] data);
    int pos;
    digest_word_t dw;
    if (act == ACT_ABSORB) begin
      blk_bytes[blk_fill] = data;
      blk_fill = blk_fill + 6'd1;
      msg_bits = msg_bits + 64'd8;
      if (blk_fill == 6'd0)
        compress_block();
    end else begin
      pos = int'(blk_fill);
      blk_bytes[6'(pos)] = PAD_MARK;
      pos = pos + 1;
      if (pos > LEN_OFFSET) begin
        while (pos < BLOCK_SIZE) begin
          blk_bytes[6'(pos)] = 8'h00;
          pos = pos + 1;
        end
        compress_block();
        pos = 0;
      end
      while (pos < LEN_OFFSET) begin
        blk_bytes[6'(pos)] = 8'h00;
        pos = pos + 1;
      end
      for (int i = 0; i < 8; i++)
        blk_bytes[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word  = chain[i];
        dw.index = 3'(i);
        dw.last  = (i == 7);
        digest_q.push_back(dw);
      end
      restart_message();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] digest mismatch, %0s: got %h, expected %h", $time, what, got, want);
    mismatches = mismatches + 1;
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    restart_message();
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst) begin
      if (msg_in.valid && msg_in.ready)
        predict_word(msg_in.action, msg_in.msg_byte);
      if (digest_out.valid && digest_out.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("word with none pending", digest_out.digest_word, 32'd0);
        end else begin
          want = digest_q.pop_front();
          if (digest_out.digest_word !== want.word)
            report_mismatch("digest_word", digest_out.digest_word, want.word);
          if (digest_out.word_index !== want.index)
            report_mismatch("word_index", 32'(digest_out.word_index), 32'(want.index));
          if (digest_out.last_word !== want.last)
            report_mismatch("last_word", 32'(digest_out.last_word), 32'(want.last));
        end
      end
      pending <= digest_q.size();
    end
  end

endmodule

### verif/sha256_stream_hasher_top_test.sv
`timescale 1ns / 1ps
// Top of the SHA-256 stream hasher testbench: clock, reset, message stimulus,
// output backpressure and the verdict. Depends on shs_pkg, shs_in_if, shs_out_if,
// sha256_digest_checker and sha256_stream_hasher_top.
module sha256_stream_hasher_top_test;
  import shs_pkg::*;

  // Number of random input words offered in each of the three random phases.
  localparam int PHASE_WORDS = 120;
  // Length of the single long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Bounds on the final drain and the quiet tail after it.
  localparam int DRAIN_LIMIT = 50000;
  localparam int TAIL_CYCLES = 300;

  logic clk;
  logic rst;

  shs_in_if  msg_ch ();
  shs_out_if dig_ch ();

  int mismatch_count;
  int pending_words;
  int words_sent;

  // Idle rates in percent. The receiver's rate and the hold-off request cross
  // process boundaries, so they are only ever updated with nonblocking writes.
  int send_idle_pct = 32;
  int recv_idle_pct = 86;
  bit hold_req      = 1'b0;

  sha256_stream_hasher_top uut (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_ch),
    .digest_out (dig_ch)
  );

  sha256_digest_checker chk (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_ch),
    .digest_out (dig_ch),
    .mismatches (mismatch_count),
    .pending    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one word on the input channel, after a random number of idle cycles,
  // and return at the clock edge where it is accepted. The valid line is only
  // written once per edge: either lowered for a gap or raised for the word.
  task automatic send_word(input logic act, input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid    <= 1'b1;
    msg_ch.action   <= act;
    msg_ch.msg_byte <= data;
    @(posedge clk);
    while (!msg_ch.ready)
      @(posedge clk);
    words_sent = words_sent + 1;
  endtask

  // A whole message: len random bytes followed by a finish word. The byte
  // carried by the finish word is random too, since the block must ignore it.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_word(ACT_ABSORB, 8'($urandom_range(0, 255)));
    send_word(ACT_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Message lengths are spread so that the short tail, the long tail (56 to 63
  // bytes left over), exact block multiples and multi-block messages all show
  // up, while most messages stay short enough to give plenty of digests.
  function automatic int pick_length();
    int kind;
    kind = $urandom_range(0, 7);
    case (kind)
      0: begin
        return $urandom_range(0, 3);
      end
      1: begin
        return $urandom_range(54, 57);
      end
      2: begin
        return $urandom_range(62, 66);
      end
      3: begin
        return $urandom_range(118, 130);
      end
      default: begin
        return $urandom_range(0, 40);
      end
    endcase
  endfunction

  // Receiver: random backpressure at the current rate, plus one long hold-off.
  // The hold-off is counted here, so the sender keeps offering words while the
  // block fills up with a finished digest and has to stall its input.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    dig_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        dig_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        dig_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int waited;
    words_sent      = 0;
    rst             = 1'b1;
    msg_ch.valid    = 1'b0;
    msg_ch.action   = ACT_ABSORB;
    msg_ch.msg_byte = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the first idling phase. The empty message first,
    // then single bytes at both extremes, the classic three-byte message, a
    // pad-marker byte followed by one more byte, and an empty message after it.
    send_word(ACT_FINISH, 8'hff);
    send_word(ACT_ABSORB, 8'h00);
    send_word(ACT_FINISH, 8'h00);
    send_word(ACT_ABSORB, 8'hff);
    send_word(ACT_FINISH, 8'h5a);
    send_word(ACT_ABSORB, 8'h61);
    send_word(ACT_ABSORB, 8'h62);
    send_word(ACT_ABSORB, 8'h63);
    send_word(ACT_FINISH, 8'ha5);
    send_word(ACT_ABSORB, 8'h80);
    send_word(ACT_ABSORB, 8'h7f);
    send_word(ACT_FINISH, 8'h01);
    send_word(ACT_FINISH, 8'hfe);

    // Phase one: the sender idles now and then, the receiver most of the time.
    while (words_sent < 13 + PHASE_WORDS)
      send_message(pick_length());

    // Phase two: the roles swap.
    send_idle_pct = 86;
    recv_idle_pct <= 32;
    while (words_sent < 13 + 2 * PHASE_WORDS)
      send_message(pick_length());

    // Phase three: no idling at all, opened by the long receiver hold-off.
    // A short first message makes sure a digest is waiting while it lasts.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req      <= 1'b1;
    send_message($urandom_range(0, 20));
    while (words_sent < 13 + 3 * PHASE_WORDS)
      send_message(pick_length());
    msg_ch.valid <= 1'b0;

    // Drain: give the checker an edge to see the last finish word, then wait
    // for the outstanding digest words and a quiet tail after them.
    @(posedge clk);
    waited = 0;
    while (pending_words != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited = waited + 1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
